// ===== rtl/psfg_pkg.sv =====
// ----------------------------------------------------------------------------
// psfg_pkg
// types and constants shared by the pressure switch fault guard
// ----------------------------------------------------------------------------
package psfg_pkg;

  localparam logic [2:0] MODE_NORMAL  = 3'd0;
  localparam logic [2:0] MODE_CONFIRM = 3'd1;
  localparam logic [2:0] MODE_FAULT   = 3'd2;
  localparam logic [2:0] MODE_RECOVER = 3'd3;
  localparam logic [2:0] MODE_LOCKED  = 3'd4;

  localparam logic REQ_TICK = 1'b0;
  localparam logic REQ_EVAL = 1'b1;

  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] REG_CONFIRM_TIME = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_RECOVERY_TIME = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_FAULT_WINDOW = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_LOCK_COUNT = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_LOCK_TIME = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_FAULT_CODE = 3'd5;

  localparam logic [7:0] COUNT_MAX = 8'hFF;

  typedef struct packed {
    logic req_type;
    logic sw_closed;
    logic compressor_running;
    logic compressor_stopped;
  } in_t;

  typedef struct packed {
    logic [2:0]  mode;
    logic        fault_active;
    logic        locked;
    logic [7:0]  faults_in_window;
    logic [15:0] fault_code;
    logic [31:0] remaining_ms;
    logic [31:0] fault_elapsed_ms;
    logic        stop_request;
    logic        restore_request;
  } out_t;

  typedef struct packed {
    logic [31:0] confirm_time_ms;
    logic [31:0] recovery_time_ms;
    logic [31:0] fault_window_ms;
    logic [7:0]  lock_fault_count;
    logic [31:0] lock_time_ms;
    logic [15:0] fault_code_value;
  } cfg_t;

endpackage

// ===== rtl/psfg_cfg.sv =====
// ----------------------------------------------------------------------------
// psfg_cfg
// configuration register file with write port
// ----------------------------------------------------------------------------
module psfg_cfg (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_we,
  input  logic [psfg_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [psfg_pkg::CFG_DATA_W-1:0]      cfg_wdata,
  output psfg_pkg::cfg_t                       cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.confirm_time_ms  <= 32'd3000;
      cfg.recovery_time_ms <= 32'd180000;
      cfg.fault_window_ms  <= 32'd3600000;
      cfg.lock_fault_count <= 8'd3;
      cfg.lock_time_ms     <= 32'd1800000;
      cfg.fault_code_value <= 16'd1;
    end else if (cfg_we) begin
      unique case (cfg_index)
        psfg_pkg::REG_CONFIRM_TIME:  cfg.confirm_time_ms  <= cfg_wdata;
        psfg_pkg::REG_RECOVERY_TIME: cfg.recovery_time_ms <= cfg_wdata;
        psfg_pkg::REG_FAULT_WINDOW:  cfg.fault_window_ms  <= cfg_wdata;
        psfg_pkg::REG_LOCK_COUNT:    cfg.lock_fault_count <= cfg_wdata[7:0];
        psfg_pkg::REG_LOCK_TIME:     cfg.lock_time_ms     <= cfg_wdata;
        psfg_pkg::REG_FAULT_CODE:    cfg.fault_code_value <= cfg_wdata[15:0];
        default: ;
      endcase
    end
  end

endmodule

// ===== rtl/psfg_core.sv =====
// ----------------------------------------------------------------------------
// psfg_core
// guard state, timers and fault window; computes the result of one transfer
// ----------------------------------------------------------------------------
module psfg_core #(
  parameter int TIMER_WIDTH = 32
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             fire,
  input  psfg_pkg::in_t    item,
  input  psfg_pkg::cfg_t   cfg,
  output psfg_pkg::out_t   result
);

  localparam logic [31:0] TMAX32 = 32'((64'd1 << TIMER_WIDTH) - 64'd1);
  localparam logic [TIMER_WIDTH-1:0] TMAX = TMAX32[TIMER_WIDTH-1:0];

  function automatic logic [TIMER_WIDTH-1:0] sat_load(input logic [31:0] v);
    sat_load = (v > TMAX32) ? TMAX : v[TIMER_WIDTH-1:0];
  endfunction

  logic [2:0]             mode_reg, mode_reg_next;
  logic [TIMER_WIDTH-1:0] countdown, countdown_next;
  logic [TIMER_WIDTH-1:0] window_remaining, window_remaining_next;
  logic [7:0]             fault_counter, fault_counter_next;
  logic [15:0]            code_reg, code_reg_next;
  logic                   saved_running, saved_running_next;
  logic [TIMER_WIDTH-1:0] elapsed_counter, elapsed_counter_next;
  logic                   stop, restore;
  logic [7:0]             cnt_base, cnt_inc;
  logic                   in_fault;

  always_comb begin
    mode_reg_next         = mode_reg;
    countdown_next        = countdown;
    window_remaining_next = window_remaining;
    fault_counter_next    = fault_counter;
    code_reg_next         = code_reg;
    saved_running_next    = saved_running;
    elapsed_counter_next  = elapsed_counter;
    stop                  = 1'b0;
    restore               = 1'b0;
    in_fault = (mode_reg == psfg_pkg::MODE_FAULT) || (mode_reg == psfg_pkg::MODE_RECOVER) ||
               (mode_reg == psfg_pkg::MODE_LOCKED);
    cnt_base = (window_remaining == '0) ? 8'd0 : fault_counter;
    cnt_inc  = (cnt_base == psfg_pkg::COUNT_MAX) ? cnt_base : cnt_base + 8'd1;

    if (item.req_type == psfg_pkg::REQ_TICK) begin
      if (countdown != '0) countdown_next = countdown - TIMER_WIDTH'(1);
      if (in_fault) begin
        if (elapsed_counter != TMAX) elapsed_counter_next = elapsed_counter + TIMER_WIDTH'(1);
      end else begin
        elapsed_counter_next = '0;
      end
      if (window_remaining != '0) begin
        window_remaining_next = window_remaining - TIMER_WIDTH'(1);
        if (window_remaining == TIMER_WIDTH'(1)) fault_counter_next = 8'd0;
      end
    end else begin
      unique case (mode_reg)
        psfg_pkg::MODE_NORMAL: begin
          code_reg_next = 16'd0;
          if (item.compressor_running && !item.sw_closed) begin
            countdown_next = sat_load(cfg.confirm_time_ms);
            mode_reg_next  = psfg_pkg::MODE_CONFIRM;
          end
        end
        psfg_pkg::MODE_CONFIRM: begin
          if (!item.compressor_running || item.sw_closed) begin
            mode_reg_next = psfg_pkg::MODE_NORMAL;
          end else if (countdown == '0) begin
            stop               = 1'b1;
            saved_running_next = item.compressor_running;
            code_reg_next      = cfg.fault_code_value;
            if (window_remaining == '0)
              window_remaining_next = sat_load(cfg.fault_window_ms);
            fault_counter_next = cnt_inc;
            if (cnt_inc >= cfg.lock_fault_count) begin
              countdown_next = sat_load(cfg.lock_time_ms);
              mode_reg_next  = psfg_pkg::MODE_LOCKED;
            end else begin
              mode_reg_next  = psfg_pkg::MODE_FAULT;
            end
          end
        end
        psfg_pkg::MODE_FAULT: begin
          stop = 1'b1;
          if (item.compressor_stopped && item.sw_closed) begin
            countdown_next = sat_load(cfg.recovery_time_ms);
            mode_reg_next  = psfg_pkg::MODE_RECOVER;
          end
        end
        psfg_pkg::MODE_RECOVER: begin
          if (!item.sw_closed) begin
            mode_reg_next = psfg_pkg::MODE_FAULT;
          end else if (countdown == '0) begin
            code_reg_next = 16'd0;
            restore       = saved_running;
            mode_reg_next = psfg_pkg::MODE_NORMAL;
          end
        end
        psfg_pkg::MODE_LOCKED: begin
          stop = 1'b1;
          if (countdown == '0) begin
            fault_counter_next = 8'd0;
            code_reg_next      = 16'd0;
            mode_reg_next      = psfg_pkg::MODE_NORMAL;
          end
        end
        default: mode_reg_next = psfg_pkg::MODE_NORMAL;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode_reg         <= psfg_pkg::MODE_NORMAL;
      countdown        <= '0;
      window_remaining <= '0;
      fault_counter    <= 8'd0;
      code_reg         <= 16'd0;
      saved_running    <= 1'b0;
      elapsed_counter  <= '0;
    end else if (fire) begin
      mode_reg         <= mode_reg_next;
      countdown        <= countdown_next;
      window_remaining <= window_remaining_next;
      fault_counter    <= fault_counter_next;
      code_reg         <= code_reg_next;
      saved_running    <= saved_running_next;
      elapsed_counter  <= elapsed_counter_next;
    end
  end

  always_comb begin
    result.mode             = mode_reg_next;
    result.fault_active     = (mode_reg_next == psfg_pkg::MODE_FAULT) ||
                              (mode_reg_next == psfg_pkg::MODE_RECOVER) ||
                              (mode_reg_next == psfg_pkg::MODE_LOCKED);
    result.locked           = (mode_reg_next == psfg_pkg::MODE_LOCKED);
    result.faults_in_window = fault_counter_next;
    result.fault_code       = code_reg_next;
    result.remaining_ms     = 32'(countdown_next);
    result.fault_elapsed_ms = 32'(elapsed_counter_next);
    result.stop_request     = stop;
    result.restore_request  = restore;
  end

endmodule

// ===== rtl/pressure_switch_fault_guard.sv =====
// ----------------------------------------------------------------------------
// pressure_switch_fault_guard
// compressor high-pressure guard with confirm, recovery and lockout timing
// ----------------------------------------------------------------------------
// result: registered on the input transfer, valid in the cycle after it
// throughput: one item per cycle while the output side accepts, set by the single state update step
// an output register holds the result while the next item is taken
// reset: synchronous, mode normal, timers and counters zero, registers default
// ----------------------------------------------------------------------------
module pressure_switch_fault_guard #(
  parameter int TIMER_WIDTH = 32
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  psfg_pkg::in_t                       in_data,
  output logic                                out_valid,
  input  logic                                out_ready,
  output psfg_pkg::out_t                      out_data,
  input  logic                                cfg_we,
  input  logic [psfg_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [psfg_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

  psfg_pkg::cfg_t cfg;
  psfg_pkg::out_t result;
  logic           fire;

  assign in_ready = !out_valid || out_ready;
  assign fire     = in_valid && in_ready;

  psfg_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  psfg_core #(
    .TIMER_WIDTH (TIMER_WIDTH)
  ) u_core (
    .clk    (clk),
    .rst    (rst),
    .fire   (fire),
    .item   (in_data),
    .cfg    (cfg),
    .result (result)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fire) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_data <= result;
    end
  end

endmodule

// ===== dv/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// drives tick and evaluation requests into pressure_switch_fault_guard with
// random idling on both sides, predicts every status word in a local model
// of the guard and compares each returned status field by field
// ----------------------------------------------------------------------------
module testbench;

  localparam int IDLE_LIMIT = 2000;
  localparam int REPORT_LIMIT = 10;
  localparam logic [31:0] TIMER_MAX = 32'hFFFF_FFFF;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  psfg_pkg::in_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  psfg_pkg::out_t out_data;
  logic cfg_we = 1'b0;
  logic [psfg_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [psfg_pkg::CFG_DATA_W-1:0] cfg_wdata = '0;

  psfg_pkg::cfg_t guard_cfg = '{confirm_time_ms: 32'd3000, recovery_time_ms: 32'd180000,
                                fault_window_ms: 32'd3600000, lock_fault_count: 8'd3,
                                lock_time_ms: 32'd1800000, fault_code_value: 16'd1};
  logic [2:0] mode_now = psfg_pkg::MODE_NORMAL;
  logic [31:0] countdown_ms = '0;
  logic [31:0] window_left = '0;
  logic [7:0] fault_tally = '0;
  logic [15:0] code_now = '0;
  logic saved_run = 1'b0;
  logic [31:0] fault_elapsed = '0;

  psfg_pkg::out_t expected_status[$];
  int mismatches = 0;
  int tx_gap_max = 6;
  int rx_gap_max = 6;
  int hold_request = 0;
  int idle_cycles = 0;

  pressure_switch_fault_guard dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data(out_data),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  always #5 clk = ~clk;

  function automatic psfg_pkg::out_t guard_step(input psfg_pkg::in_t req);
    psfg_pkg::out_t res;
    logic stop_req;
    logic restore_req;
    stop_req = 1'b0;
    restore_req = 1'b0;
    if (req.req_type == psfg_pkg::REQ_TICK) begin
      if (countdown_ms != 0) countdown_ms--;
      if (mode_now == psfg_pkg::MODE_FAULT || mode_now == psfg_pkg::MODE_RECOVER ||
          mode_now == psfg_pkg::MODE_LOCKED) begin
        if (fault_elapsed != TIMER_MAX) fault_elapsed++;
      end else begin
        fault_elapsed = '0;
      end
      if (window_left != 0) begin
        window_left--;
        if (window_left == 0) fault_tally = '0;
      end
    end else begin
      unique case (mode_now)
        psfg_pkg::MODE_NORMAL: begin
          code_now = '0;
          if (req.compressor_running && !req.sw_closed) begin
            countdown_ms = guard_cfg.confirm_time_ms;
            mode_now = psfg_pkg::MODE_CONFIRM;
          end
        end
        psfg_pkg::MODE_CONFIRM: begin
          if (!req.compressor_running || req.sw_closed) begin
            mode_now = psfg_pkg::MODE_NORMAL;
          end else if (countdown_ms == 0) begin
            stop_req = 1'b1;
            saved_run = req.compressor_running;
            code_now = guard_cfg.fault_code_value;
            if (window_left == 0) begin
              window_left = guard_cfg.fault_window_ms;
              fault_tally = '0;
            end
            if (fault_tally != psfg_pkg::COUNT_MAX) fault_tally++;
            if (fault_tally >= guard_cfg.lock_fault_count) begin
              countdown_ms = guard_cfg.lock_time_ms;
              mode_now = psfg_pkg::MODE_LOCKED;
            end else begin
              mode_now = psfg_pkg::MODE_FAULT;
            end
          end
        end
        psfg_pkg::MODE_FAULT: begin
          stop_req = 1'b1;
          if (req.compressor_stopped && req.sw_closed) begin
            countdown_ms = guard_cfg.recovery_time_ms;
            mode_now = psfg_pkg::MODE_RECOVER;
          end
        end
        psfg_pkg::MODE_RECOVER: begin
          if (!req.sw_closed) begin
            mode_now = psfg_pkg::MODE_FAULT;
          end else if (countdown_ms == 0) begin
            code_now = '0;
            restore_req = saved_run;
            mode_now = psfg_pkg::MODE_NORMAL;
          end
        end
        psfg_pkg::MODE_LOCKED: begin
          stop_req = 1'b1;
          if (countdown_ms == 0) begin
            fault_tally = '0;
            code_now = '0;
            mode_now = psfg_pkg::MODE_NORMAL;
          end
        end
        default: mode_now = psfg_pkg::MODE_NORMAL;
      endcase
    end
    res.mode = mode_now;
    res.fault_active = (mode_now == psfg_pkg::MODE_FAULT || mode_now == psfg_pkg::MODE_RECOVER ||
                        mode_now == psfg_pkg::MODE_LOCKED);
    res.locked = (mode_now == psfg_pkg::MODE_LOCKED);
    res.faults_in_window = fault_tally;
    res.fault_code = code_now;
    res.remaining_ms = countdown_ms;
    res.fault_elapsed_ms = fault_elapsed;
    res.stop_request = stop_req;
    res.restore_request = restore_req;
    return res;
  endfunction

  function automatic psfg_pkg::in_t make_req(input logic kind, input logic closed,
                                             input logic running, input logic stopped);
    psfg_pkg::in_t req;
    req.req_type = kind;
    req.sw_closed = closed;
    req.compressor_running = running;
    req.compressor_stopped = stopped;
    return req;
  endfunction

  // random requests; most evaluations are shaped to push the guard forward from its present mode
  function automatic psfg_pkg::in_t random_request();
    psfg_pkg::in_t req;
    req = 4'($urandom);
    if (req.req_type == psfg_pkg::REQ_EVAL && $urandom_range(3) != 0) begin
      unique case (mode_now)
        psfg_pkg::MODE_NORMAL, psfg_pkg::MODE_CONFIRM: begin
          req.compressor_running = 1'b1;
          req.sw_closed = ($urandom_range(4) == 0);
        end
        psfg_pkg::MODE_FAULT: begin
          req.sw_closed = ($urandom_range(4) != 0);
          req.compressor_stopped = ($urandom_range(3) != 0);
        end
        psfg_pkg::MODE_RECOVER: req.sw_closed = ($urandom_range(5) != 0);
        default: ;
      endcase
    end
    return req;
  endfunction

  function automatic psfg_pkg::cfg_t small_settings();
    psfg_pkg::cfg_t c;
    c.confirm_time_ms = $urandom_range(5);
    c.recovery_time_ms = $urandom_range(5);
    c.fault_window_ms = $urandom_range(30);
    c.lock_fault_count = 8'($urandom_range(4));
    c.lock_time_ms = $urandom_range(6);
    c.fault_code_value = 16'($urandom);
    return c;
  endfunction

  function automatic void note_mismatch(input string msg);
    mismatches++;
    if (mismatches <= REPORT_LIMIT) $display("%0t mismatch: %s", $time, msg);
  endfunction

  function automatic void check_field(input string name, input logic [31:0] want,
                                      input logic [31:0] got);
    if (want !== got) note_mismatch($sformatf("%s expected %0h, got %0h", name, want, got));
  endfunction

  task automatic send_request(input psfg_pkg::in_t req);
    int gap;
    gap = $urandom_range(tx_gap_max);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data <= req;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
    expected_status.push_back(guard_step(req));
  endtask

  task automatic run_random(input int count);
    repeat (count) send_request(random_request());
  endtask

  task automatic wait_quiet();
    in_valid <= 1'b0;
    while (expected_status.size() != 0) @(negedge clk);
    repeat (2) @(negedge clk);
  endtask

  task automatic load_settings(input psfg_pkg::cfg_t c);
    logic [psfg_pkg::CFG_IDX_W-1:0] idx_list [6];
    logic [psfg_pkg::CFG_DATA_W-1:0] word [6];
    idx_list[0] = psfg_pkg::REG_CONFIRM_TIME;
    idx_list[1] = psfg_pkg::REG_RECOVERY_TIME;
    idx_list[2] = psfg_pkg::REG_FAULT_WINDOW;
    idx_list[3] = psfg_pkg::REG_LOCK_COUNT;
    idx_list[4] = psfg_pkg::REG_LOCK_TIME;
    idx_list[5] = psfg_pkg::REG_FAULT_CODE;
    word[0] = c.confirm_time_ms;
    word[1] = c.recovery_time_ms;
    word[2] = c.fault_window_ms;
    word[3] = {24'($urandom), c.lock_fault_count};
    word[4] = c.lock_time_ms;
    word[5] = {16'($urandom), c.fault_code_value};
    cfg_we <= 1'b1;
    for (int i = 0; i < 6; i++) begin
      cfg_index <= idx_list[i];
      cfg_wdata <= word[i];
      @(negedge clk);
    end
    cfg_we <= 1'b0;
    guard_cfg = c;
  endtask

  task automatic recover_to_normal();
    psfg_pkg::in_t req;
    while (mode_now != psfg_pkg::MODE_NORMAL) begin
      req = make_req(psfg_pkg::REQ_EVAL, 1'b1, 1'b0, 1'b1);
      if ((mode_now == psfg_pkg::MODE_RECOVER || mode_now == psfg_pkg::MODE_LOCKED) &&
          countdown_ms != 0)
        req.req_type = psfg_pkg::REQ_TICK;
      send_request(req);
    end
  endtask

  task automatic test_reset_defaults();
    send_request(make_req(psfg_pkg::REQ_TICK, 1'b1, 1'b1, 1'b1));
    send_request(make_req(psfg_pkg::REQ_EVAL, 1'b1, 1'b1, 1'b0));
    send_request(make_req(psfg_pkg::REQ_EVAL, 1'b0, 1'b0, 1'b0));
    send_request(make_req(psfg_pkg::REQ_EVAL, 1'b0, 1'b1, 1'b0));
    send_request(make_req(psfg_pkg::REQ_TICK, 1'b0, 1'b1, 1'b0));
    send_request(make_req(psfg_pkg::REQ_TICK, 1'b1, 1'b0, 1'b1));
    send_request(make_req(psfg_pkg::REQ_EVAL, 1'b0, 1'b1, 1'b0));
    send_request(make_req(psfg_pkg::REQ_EVAL, 1'b0, 1'b0, 1'b1));
    send_request(make_req(psfg_pkg::REQ_EVAL, 1'b0, 1'b1, 1'b0));
    send_request(make_req(psfg_pkg::REQ_EVAL, 1'b1, 1'b1, 1'b0));
  endtask

  // zero lock count locks on the first fault
  task automatic test_zero_timers();
    wait_quiet();
    load_settings('{confirm_time_ms: '0, recovery_time_ms: '0, fault_window_ms: '0,
                    lock_fault_count: '0, lock_time_ms: '0, fault_code_value: 16'hFFFF});
    send_request(make_req(psfg_pkg::REQ_EVAL, 1'b0, 1'b1, 1'b0));
    send_request(make_req(psfg_pkg::REQ_EVAL, 1'b0, 1'b1, 1'b1));
    send_request(make_req(psfg_pkg::REQ_TICK, 1'b0, 1'b0, 1'b0));
    send_request(make_req(psfg_pkg::REQ_EVAL, 1'b1, 1'b0, 1'b1));
    send_request(make_req(psfg_pkg::REQ_TICK, 1'b1, 1'b1, 1'b1));
  endtask

  // zero window restarts the count at every fault
  task automatic test_window_zero();
    wait_quiet();
    load_settings('{confirm_time_ms: '0, recovery_time_ms: '0, fault_window_ms: '0,
                    lock_fault_count: 8'd2, lock_time_ms: '0, fault_code_value: 16'h5A5A});
    send_request(make_req(psfg_pkg::REQ_EVAL, 1'b0, 1'b1, 1'b0));
    send_request(make_req(psfg_pkg::REQ_EVAL, 1'b0, 1'b1, 1'b0));
    send_request(make_req(psfg_pkg::REQ_EVAL, 1'b1, 1'b1, 1'b0));
    send_request(make_req(psfg_pkg::REQ_TICK, 1'b0, 1'b0, 1'b1));
    send_request(make_req(psfg_pkg::REQ_EVAL, 1'b1, 1'b0, 1'b1));
    send_request(make_req(psfg_pkg::REQ_EVAL, 1'b0, 1'b0, 1'b1));
    send_request(make_req(psfg_pkg::REQ_EVAL, 1'b1, 1'b1, 1'b1));
    send_request(make_req(psfg_pkg::REQ_EVAL, 1'b1, 1'b1, 1'b0));
    send_request(make_req(psfg_pkg::REQ_EVAL, 1'b0, 1'b1, 1'b0));
    send_request(make_req(psfg_pkg::REQ_EVAL, 1'b0, 1'b1, 1'b0));
    send_request(make_req(psfg_pkg::REQ_EVAL, 1'b1, 1'b0, 1'b1));
    send_request(make_req(psfg_pkg::REQ_EVAL, 1'b1, 1'b0, 1'b0));
  endtask

  // full-scale timers: confirm never expires, so no fault can start here
  task automatic test_timer_limits();
    recover_to_normal();
    wait_quiet();
    load_settings('{confirm_time_ms: TIMER_MAX, recovery_time_ms: TIMER_MAX,
                    fault_window_ms: TIMER_MAX, lock_fault_count: psfg_pkg::COUNT_MAX,
                    lock_time_ms: TIMER_MAX, fault_code_value: '0});
    send_request(make_req(psfg_pkg::REQ_EVAL, 1'b0, 1'b1, 1'b0));
    send_request(make_req(psfg_pkg::REQ_TICK, 1'b0, 1'b1, 1'b0));
    run_random(40);
    recover_to_normal();
  endtask

  task automatic test_random_settings();
    for (int round = 0; round < 4; round++) begin
      wait_quiet();
      load_settings(small_settings());
      tx_gap_max = (round == 1 || round == 3) ? 0 : 6;
      rx_gap_max = (round == 1 || round == 2) ? 0 : 6;
      run_random(70);
    end
    tx_gap_max = 6;
    rx_gap_max = 6;
  endtask

  task automatic test_backpressure();
    tx_gap_max = 0;
    rx_gap_max = 0;
    hold_request = 50;
    run_random(12);
    // sender holds off until every status has come back
    wait_quiet();
    tx_gap_max = 6;
    rx_gap_max = 6;
    run_random(10);
  endtask

  // long window with top lock count lets the fault count climb
  task automatic test_long_window();
    wait_quiet();
    load_settings('{confirm_time_ms: 32'd1, recovery_time_ms: 32'd1,
                    fault_window_ms: TIMER_MAX, lock_fault_count: psfg_pkg::COUNT_MAX,
                    lock_time_ms: 32'd2, fault_code_value: 16'($urandom)});
    run_random(60);
  endtask

  initial begin : result_sink
    int gap;
    int hold;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if (hold_request > 0) begin
        hold = hold_request;
        hold_request = 0;
        out_ready <= 1'b0;
        repeat (hold) @(negedge clk);
      end
      gap = $urandom_range(rx_gap_max);
      if (gap > 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
      @(negedge clk);
    end
  end

  always @(posedge clk) begin : result_check
    psfg_pkg::out_t want;
    if (!rst && out_valid && out_ready) begin
      if (expected_status.size() == 0) begin
        note_mismatch($sformatf("unexpected status %h", out_data));
      end else begin
        want = expected_status.pop_front();
        check_field("mode", 32'(want.mode), 32'(out_data.mode));
        check_field("fault_active", 32'(want.fault_active), 32'(out_data.fault_active));
        check_field("locked", 32'(want.locked), 32'(out_data.locked));
        check_field("faults_in_window", 32'(want.faults_in_window),
                    32'(out_data.faults_in_window));
        check_field("fault_code", 32'(want.fault_code), 32'(out_data.fault_code));
        check_field("remaining_ms", want.remaining_ms, out_data.remaining_ms);
        check_field("fault_elapsed_ms", want.fault_elapsed_ms, out_data.fault_elapsed_ms);
        check_field("stop_request", 32'(want.stop_request), 32'(out_data.stop_request));
        check_field("restore_request", 32'(want.restore_request),
                    32'(out_data.restore_request));
      end
    end
  end

  // no transfer on either side for too long
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("FAIL pressure_switch_fault_guard");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_reset_defaults();
    test_zero_timers();
    test_window_zero();
    test_timer_limits();
    test_random_settings();
    test_backpressure();
    test_long_window();
    wait_quiet();
    if (mismatches == 0 && expected_status.size() == 0) begin
      $display("PASS pressure_switch_fault_guard");
    end else begin
      $display("FAIL pressure_switch_fault_guard");
    end
    $finish;
  end

endmodule
